/* hw/rtl/tksk_pkg.sv */
// ----------------------------------------------------------------------------
// tksk_pkg
// Shared types and constants of the top-k similarity keeper.
// ----------------------------------------------------------------------------
`default_nettype none

package tksk_pkg;

    localparam int DEF_MAX_SLOTS = 16;

    localparam int IDX_W  = 20;
    localparam int SIM_W  = 16;
    localparam int RANK_W = 5;
    localparam int SLOT_W = 5;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [0:0] FUNC_OFFER   = 1'b0;
    localparam logic [0:0] FUNC_READOUT = 1'b1;

    localparam logic [0:0] REG_SLOTS = 1'b0;

    localparam logic [SLOT_W-1:0] SLOTS_RST = 5'd16;

    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_SHIFT  = 2'd2;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic [SIM_W-1:0] sim;
    } t_entry;

    typedef struct packed {
        logic [1:0] op;
        t_entry     cand;
    } t_cell_ctl;

endpackage

`default_nettype wire

/* hw/rtl/tksk_if.sv */
// ----------------------------------------------------------------------------
// tksk_if
// Valid/ready channels for candidate items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface tksk_cand_if
    import tksk_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [0:0]        func;
    logic [IDX_W-1:0]  cand_index;
    logic signed [SIM_W-1:0] cand_similarity;

    modport source (output valid, func, cand_index, cand_similarity, input ready);
    modport sink   (input valid, func, cand_index, cand_similarity, output ready);
endinterface

interface tksk_res_if
    import tksk_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [RANK_W-1:0] rank;
    logic [IDX_W-1:0]  nb_index;
    logic signed [SIM_W-1:0] nb_similarity;
    logic              valid_res;
    logic              last;

    modport source (output valid, rank, nb_index, nb_similarity, valid_res, last,
                    input ready);
    modport sink   (input valid, rank, nb_index, nb_similarity, valid_res, last,
                    output ready);
endinterface

`default_nettype wire

/* hw/rtl/tksk_cfg.sv */
// ----------------------------------------------------------------------------
// tksk_cfg
// APB register file holding the slots_in_use register.
// ----------------------------------------------------------------------------
`default_nettype none

module tksk_cfg
    import tksk_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output logic      [SLOT_W-1:0] o_slots
);

    logic [SLOT_W-1:0] r_slots;
    logic              w_sel_slots;

    assign w_sel_slots = (paddr[APB_AW-1:2] == REG_SLOTS);
    assign pready      = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= SLOTS_RST;
        end else if (psel && penable && pwrite && w_sel_slots) begin
            r_slots <= pwdata[SLOT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_sel_slots) begin
            prdata[SLOT_W-1:0] = r_slots;
        end
    end

    assign o_slots = r_slots;

endmodule

`default_nettype wire

/* hw/rtl/tksk_cell.sv */
// ----------------------------------------------------------------------------
// tksk_cell
// One slot of the sorted chain: insert, hold or shift toward the head.
// ----------------------------------------------------------------------------
`default_nettype none

module tksk_cell
    import tksk_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cell_ctl i_ctl,
    input  wire logic      i_keep,
    input  wire t_entry    i_left,
    input  wire logic      i_left_stay,
    input  wire t_entry    i_right,
    output t_entry         o_ent,
    output logic           o_stay
);

    logic             r_valid;
    logic [IDX_W-1:0] r_idx;
    logic [SIM_W-1:0] r_sim;
    t_entry           n_ent;

    assign o_ent  = '{valid: r_valid, idx: r_idx, sim: r_sim};
    assign o_stay = r_valid && ($signed(r_sim) >= $signed(i_ctl.cand.sim));

    always_comb begin
        n_ent = o_ent;
        case (i_ctl.op)
            OP_INSERT: begin
                if (o_stay) begin
                    n_ent = o_ent;
                end else if (i_left_stay) begin
                    n_ent = i_ctl.cand;
                end else begin
                    n_ent = i_left;
                end
            end
            OP_SHIFT: n_ent = i_right;
            default:  n_ent = o_ent;
        endcase
        n_ent.valid = n_ent.valid && i_keep;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_ent.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_ent.idx;
        r_sim <= n_ent.sim;
    end

endmodule

`default_nettype wire

/* hw/rtl/top_k_similarity_keeper.sv */
// ----------------------------------------------------------------------------
// top_k_similarity_keeper
// Keeps the best candidates by similarity in a sorted chain of slot cells.
// ----------------------------------------------------------------------------
// i_cand carries items: func 0 offers a candidate, func 1 reads the list out.
// o_res carries one result per kept entry on readout, rank 1 first, with last
// set on the final one; an empty list gives one result with valid_res 0.
// The APB port sets slots_in_use; writes trim the list at once.
// During an offer i_cand keeps ready high and the next item is taken in the following cycle:
// the candidate is broadcast to all cells and each cell compares and shifts.
// A readout of N entries (one result for an empty list) moves one result per
// cycle into the output register while o_res does not stall, the first once
// the state register has entered the read state; i_cand drops ready until the
// last result has moved. The chain shifts one slot per result.
// When o_res stalls, the chain holds and the output register keeps its item.
// Reset empties the list, sets slots_in_use to 16 and clears the output.
// ----------------------------------------------------------------------------
`default_nettype none

module top_k_similarity_keeper
    import tksk_pkg::*;
#(
    parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    tksk_cand_if.sink              i_cand,
    tksk_res_if.source             o_res,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic              r_state;
    logic              n_state;
    logic [SLOT_W-1:0] w_slots;
    logic              w_accept;
    logic              w_emit;
    logic              w_last;
    t_cell_ctl         w_ctl;

    t_entry            w_ent  [0:MAX_SLOTS];
    logic              w_stay [0:MAX_SLOTS-1];
    logic              w_keep [0:MAX_SLOTS-1];

    logic              r_out_valid;
    logic [RANK_W-1:0] r_rank;
    logic [RANK_W-1:0] r_out_rank;
    logic [IDX_W-1:0]  r_out_idx;
    logic [SIM_W-1:0]  r_out_sim;
    logic              r_out_vres;
    logic              r_out_last;

    tksk_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_slots (w_slots)
    );

    assign i_cand.ready = (r_state == ST_IDLE);
    assign w_accept     = i_cand.valid && i_cand.ready;
    assign w_emit       = (r_state == ST_READ) && (!r_out_valid || o_res.ready);

    always_comb begin
        w_ctl.cand.valid = 1'b1;
        w_ctl.cand.idx   = i_cand.cand_index;
        w_ctl.cand.sim   = i_cand.cand_similarity;
        if (w_accept && (i_cand.func == FUNC_OFFER)) begin
            w_ctl.op = OP_INSERT;
        end else if (w_emit) begin
            w_ctl.op = OP_SHIFT;
        end else begin
            w_ctl.op = OP_HOLD;
        end
    end

    assign w_ent[MAX_SLOTS] = '0;

    for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
        t_entry w_left;
        logic   w_left_stay;

        if (g == 0) begin : g_head
            assign w_left      = '{valid: 1'b1, idx: '0, sim: '0};
            assign w_left_stay = 1'b1;
        end else begin : g_body
            assign w_left      = w_ent[g-1];
            assign w_left_stay = w_stay[g-1];
        end

        assign w_keep[g] = (32'(w_slots) > g);

        tksk_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_keep      (w_keep[g]),
            .i_left      (w_left),
            .i_left_stay (w_left_stay),
            .i_right     (w_ent[g+1]),
            .o_ent       (w_ent[g]),
            .o_stay      (w_stay[g])
        );
    end

    assign w_last = !w_ent[0].valid || !w_ent[1].valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_cand.func == FUNC_READOUT)) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (w_emit && w_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_rank      <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_rank <= RANK_W'(1);
            end else if (w_emit) begin
                r_rank <= r_rank + RANK_W'(1);
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_last <= w_last;
            r_out_vres <= w_ent[0].valid;
            if (w_ent[0].valid) begin
                r_out_rank <= r_rank;
                r_out_idx  <= w_ent[0].idx;
                r_out_sim  <= w_ent[0].sim;
            end else begin
                r_out_rank <= '0;
                r_out_idx  <= '0;
                r_out_sim  <= '0;
            end
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.rank          = r_out_rank;
    assign o_res.nb_index      = r_out_idx;
    assign o_res.nb_similarity = r_out_sim;
    assign o_res.valid_res     = r_out_vres;
    assign o_res.last          = r_out_last;

endmodule

`default_nettype wire

/* hw/rtl/tksk_checker.sv */
// ----------------------------------------------------------------------------
// tksk_checker
// Port-level checks of the top-k similarity keeper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tksk_checker
    import tksk_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire logic [RANK_W-1:0] i_rank,
    input wire logic [IDX_W-1:0]  i_nb_index,
    input wire logic [SIM_W-1:0]  i_nb_similarity,
    input wire logic              i_valid_res,
    input wire logic              i_last
);

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_rank)
            && $stable(i_last) && $stable(i_nb_index))
        else $error("result item changed while stalled");

    a_empty_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_valid_res |-> i_last && (i_rank == '0)
            && (i_nb_index == '0) && (i_nb_similarity == '0))
        else $error("empty readout item malformed");

    a_rank_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_valid_res |-> (i_rank != '0))
        else $error("kept entry with rank zero");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result item shown right after reset");

endmodule

bind top_k_similarity_keeper tksk_checker u_tksk_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_res.valid),
    .i_out_ready     (o_res.ready),
    .i_rank          (o_res.rank),
    .i_nb_index      (o_res.nb_index),
    .i_nb_similarity (o_res.nb_similarity),
    .i_valid_res     (o_res.valid_res),
    .i_last          (o_res.last)
);

`default_nettype wire
